>>> src/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the control-voltage loop recorder.
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int KNOB_W     = 10;
  localparam int WET_W      = 9;
  localparam int FUNC_W     = 2;
  localparam int LEVEL_W    = 16;
  localparam int POS_W      = 10;
  localparam int LEN_CFG_W  = 11;
  localparam int TICK_W     = 10;
  localparam int INTERVAL_W = 9;

  localparam int LOOP_DEPTH_DEF = 1024;

  localparam logic [TICK_W-1:0]     TICK_MAX       = 10'd1023;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 9'd36;
  localparam logic [WET_W-1:0]      WET_ONE        = 9'd256;
  localparam logic [SAMPLE_W-1:0]   FULL_SCALE_CODE = 10'd1023;

  localparam logic [LEN_CFG_W-1:0] LOOP_LENGTH_RESET    = 11'd256;
  localparam logic [LEVEL_W-1:0]   DAC_FULL_SCALE_RESET = 16'hFFFF;

  localparam int  CFG_ADDR_W = 3;
  localparam logic REG_LOOP_LENGTH    = 1'b0;
  localparam logic REG_DAC_FULL_SCALE = 1'b1;

  localparam logic [FUNC_W-1:0] FUNC_PLAY    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_OVERDUB = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ERASE   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_PLAY_ALT = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [KNOB_W-1:0]   period_knob;
    logic [WET_W-1:0]    wet;
    logic [SAMPLE_W-1:0] cv_in;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic [LEVEL_W-1:0]  cv_level;
    logic [POS_W-1:0]    position;
    logic                recording;
  } out_t;

endpackage

>>> src/cv_loop_recorder.sv
// ----------------------------------------------------------------------------
// cv_loop_recorder
// Tick-driven control-voltage looper: records a loop, then plays, overdubs
// or erases it, and reports each sample step with its DAC level.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one tick item per transfer (valid/stall). Every item advances the
//           tick counter; only items that fire a sample step produce a result.
//   out_* : one result per sample step, in order (valid/stall).
//   APB   : loop_length at 0x0, dac_full_scale at 0x4; write only while idle.
// A result passes through stages 1, 2 and 3 and the result queue to out_*.
// Throughput: one item per cycle unless in_stall. The sample store has one
//   read and one write port; an overdub reads at transfer and writes back the
//   cycle after, with forwarding into a read of the same entry in that cycle.
// An 8-entry result queue sits before out_*; in_stall rises only while the
//   queue plus the results in flight fill it, so items keep flowing while a
//   result waits for the receiver.
// Reset: counters and registers return to their defaults. The store needs
//   no clearing pass: no entry is read before the record pass writes it.
// ----------------------------------------------------------------------------
module cv_loop_recorder
  import clr_pkg::*;
#(
  parameter int LOOP_DEPTH = LOOP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW      = $clog2(LOOP_DEPTH);
  localparam int LEN_W   = $clog2(LOOP_DEPTH + 1);
  localparam int CMP_W   = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
  localparam int MIX_W   = SAMPLE_W + WET_W;
  localparam int PROD_W  = SAMPLE_W + LEVEL_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int Q_W     = SUM_W - 10;
  localparam int QD      = 8;
  localparam int QA      = $clog2(QD);
  localparam int QC      = $clog2(QD + 1);

  // configuration
  logic [LEN_CFG_W-1:0] loop_length_r;
  logic [LEVEL_W-1:0]   dac_fs_r;
  logic                 cfg_wr;

  // loop state
  logic [TICK_W-1:0]     ticks_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic [LEN_W-1:0]      rec_cnt_r;
  logic [AW-1:0]         loop_pos_r;

  // sample store
  logic [SAMPLE_W-1:0] sample_mem [LOOP_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                fwd_hit_r;
  logic [SAMPLE_W-1:0] fwd_data_r;

  // stage 1
  logic                s1_vld_r;
  logic                s1_rec_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [WET_W-1:0]    s1_wet_r;
  logic [SAMPLE_W-1:0] s1_cv_r;
  logic [AW-1:0]       s1_pos_r;

  // stage 2
  logic                s2_vld_r;
  logic                s2_rec_r;
  logic [SAMPLE_W-1:0] s2_val_r;
  logic [POS_W-1:0]    s2_pos_r;

  // stage 3
  logic                s3_vld_r;
  logic                s3_rec_r;
  logic [SAMPLE_W-1:0] s3_val_r;
  logic [POS_W-1:0]    s3_pos_r;
  logic [PROD_W-1:0]   s3_prod_r;

  // result queue
  out_t            q_mem [QD];
  logic [QA-1:0]   q_wr_r;
  logic [QA-1:0]   q_rd_r;
  logic [QC-1:0]   q_cnt_r;
  logic [QC-1:0]   occ_r;
  logic [QC-1:0]   occ_nxt;

  // step logic
  logic                in_xfer;
  logic                out_xfer;
  logic                fire;
  logic                fire_xfer;
  logic [TICK_W-1:0]   ticks_inc;
  logic [CMP_W-1:0]    len_ext;
  logic [LEN_W-1:0]    len;
  logic                rec;
  logic [AW-1:0]       pos;
  logic [LEN_W-1:0]    pos_inc;
  logic [AW-1:0]       loop_pos_nxt;
  logic [WET_W-1:0]    wet_sat;
  logic [SAMPLE_W-1:0] old_val;
  logic [MIX_W-1:0]    mix;
  logic                s1_wr;
  logic [SAMPLE_W-1:0] s1_wdata;
  logic [SAMPLE_W-1:0] s1_val;
  logic                rec_wr;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [SUM_W-1:0]    div_sum;
  logic [Q_W-1:0]      div_q0;
  logic [SUM_W-1:0]    div_rem;
  logic [Q_W-1:0]      div_q;
  out_t                push_item;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_valid = (q_cnt_r != '0);
  assign out_xfer = out_valid & ~out_stall;
  assign out_data = q_mem[q_rd_r];
  assign in_stall = (occ_r == QC'(QD));

  always_comb begin
    case (paddr[2])
      REG_LOOP_LENGTH:    prdata = 32'(loop_length_r);
      REG_DAC_FULL_SCALE: prdata = 32'(dac_fs_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_length_r <= LOOP_LENGTH_RESET;
      dac_fs_r      <= DAC_FULL_SCALE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LOOP_LENGTH:    loop_length_r <= pwdata[LEN_CFG_W-1:0];
        REG_DAC_FULL_SCALE: dac_fs_r      <= pwdata[LEVEL_W-1:0];
        default:            ;
      endcase
    end
  end

  // tick counting, record/loop position
  always_comb begin
    ticks_inc = (ticks_r < TICK_MAX) ? ticks_r + TICK_W'(1) : ticks_r;
    fire      = ticks_inc > TICK_W'(interval_r);
    fire_xfer = in_xfer & fire;

    if (loop_length_r == '0) begin
      len_ext = CMP_W'(1);
    end else if (CMP_W'(loop_length_r) > CMP_W'(LOOP_DEPTH)) begin
      len_ext = CMP_W'(LOOP_DEPTH);
    end else begin
      len_ext = CMP_W'(loop_length_r);
    end
    len = len_ext[LEN_W-1:0];

    rec = rec_cnt_r < len;
    if (rec) begin
      pos = AW'(rec_cnt_r);
    end else if (LEN_W'(loop_pos_r) >= len) begin
      pos = '0;
    end else begin
      pos = loop_pos_r;
    end
    pos_inc      = LEN_W'(pos) + LEN_W'(1);
    loop_pos_nxt = (pos_inc >= len) ? '0 : AW'(pos_inc);

    wet_sat = (in_data.wet > WET_ONE) ? WET_ONE : in_data.wet;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= '0;
      interval_r <= INTERVAL_RESET;
      rec_cnt_r  <= '0;
      loop_pos_r <= '0;
    end else if (in_xfer) begin
      ticks_r <= fire ? '0 : ticks_inc;
      if (fire) begin
        interval_r <= in_data.period_knob[KNOB_W-1:1];
        if (rec) begin
          rec_cnt_r <= rec_cnt_r + LEN_W'(1);
        end else begin
          loop_pos_r <= loop_pos_nxt;
        end
      end
    end
  end

  // stage 1: read data arrives, blend and write back
  always_comb begin
    old_val = fwd_hit_r ? fwd_data_r : rd_data_r;
    mix = (MIX_W'(s1_cv_r) * MIX_W'(s1_wet_r)
         + MIX_W'(old_val) * MIX_W'(WET_ONE - s1_wet_r)) >> 8;
    s1_wr = s1_vld_r & ~s1_rec_r &
            ((s1_func_r == FUNC_OVERDUB) || (s1_func_r == FUNC_ERASE));
    s1_wdata = (s1_func_r == FUNC_OVERDUB) ? mix[SAMPLE_W-1:0] : s1_cv_r;
    if (s1_rec_r) begin
      s1_val = s1_cv_r;
    end else if (s1_wr) begin
      s1_val = s1_wdata;
    end else begin
      s1_val = old_val;
    end

    rec_wr    = fire_xfer & rec;
    mem_we    = rec_wr | s1_wr;
    mem_waddr = rec_wr ? pos : s1_pos_r;
    mem_wdata = rec_wr ? in_data.cv_in : s1_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[mem_waddr] <= mem_wdata;
    end
    if (fire_xfer) begin
      rd_data_r  <= sample_mem[pos];
      fwd_hit_r  <= s1_wr && (s1_pos_r == pos);
      fwd_data_r <= s1_wdata;
      s1_rec_r   <= rec;
      s1_func_r  <= in_data.func;
      s1_wet_r   <= wet_sat;
      s1_cv_r    <= in_data.cv_in;
      s1_pos_r   <= pos;
    end
  end

  // stages 2 and 3: DAC scaling
  always_ff @(posedge clk) begin
    s2_rec_r  <= s1_rec_r;
    s2_val_r  <= s1_val;
    s2_pos_r  <= POS_W'(s1_pos_r);
    s3_rec_r  <= s2_rec_r;
    s3_val_r  <= s2_val_r;
    s3_pos_r  <= s2_pos_r;
    s3_prod_r <= PROD_W'(s2_val_r) * PROD_W'(dac_fs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= fire_xfer;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // divide by 1023: x/1024 * (1 + 2^-10 + 2^-20) is short by at most one
  always_comb begin
    div_sum = SUM_W'(s3_prod_r) + SUM_W'(s3_prod_r >> 10) + SUM_W'(s3_prod_r >> 20);
    div_q0  = div_sum[SUM_W-1:10];
    div_rem = SUM_W'(s3_prod_r) - SUM_W'(div_q0) * SUM_W'(FULL_SCALE_CODE);
    div_q   = (div_rem >= SUM_W'(FULL_SCALE_CODE)) ? div_q0 + Q_W'(1) : div_q0;

    push_item.sample_value = s3_val_r;
    push_item.cv_level     = div_q[LEVEL_W-1:0];
    push_item.position     = s3_pos_r;
    push_item.recording    = s3_rec_r;
  end

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      q_mem[q_wr_r] <= push_item;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (fire_xfer) occ_nxt = occ_nxt + QC'(1);
    if (out_xfer)  occ_nxt = occ_nxt - QC'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
      occ_r   <= '0;
    end else begin
      occ_r <= occ_nxt;
      if (s3_vld_r) q_wr_r <= q_wr_r + QA'(1);
      if (out_xfer) q_rd_r <= q_rd_r + QA'(1);
      case ({s3_vld_r, out_xfer})
        2'b10:   q_cnt_r <= q_cnt_r + QC'(1);
        2'b01:   q_cnt_r <= q_cnt_r - QC'(1);
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  // assertions
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == q_cnt_r + QC'(s1_vld_r) + QC'(s2_vld_r) + QC'(s3_vld_r))
    else $error("result occupancy count out of step with pipeline and queue");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_wr && s1_wr))
    else $error("record write collides with loop write-back");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (q_cnt_r < QC'(QD)) || out_xfer)
    else $error("result pushed into a full queue");

  a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
    fire_xfer |=> ticks_r == '0)
    else $error("tick count not restarted after a sample step");

endmodule
